>>> hdl/ibls_pkg.sv
// ---------------------------------------------------------------------------
// ibls_pkg
// Shared types and constants for the interval booking table with linear scan.
// ---------------------------------------------------------------------------
`default_nettype none

package ibls_pkg;

    // table size and stored time width
    localparam int CAPACITY   = 1024;
    localparam int TIME_BITS  = 30;

    // derived widths
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENTRY_BITS = 2 * TIME_BITS;

    // fixed field widths of the request and the response
    localparam int FIELD_TIME_BITS  = 30;
    localparam int FIELD_COUNT_BITS = 11;

    // response status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [FIELD_TIME_BITS-1:0] start_time;
        logic [FIELD_TIME_BITS-1:0] end_time;
    } t_req;

    typedef struct packed {
        logic [1:0]                  status;
        logic [FIELD_COUNT_BITS-1:0] entries_used;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hdl/interval_booking_linear_scan.sv
// ---------------------------------------------------------------------------
// interval_booking_linear_scan
// Reservation table for half-open intervals: each request is checked against
// the stored intervals and appended when nothing overlaps and room is left.
// ---------------------------------------------------------------------------
// a request is scanned against the stored intervals in order, with one read of
//   the interval RAM per cycle, before its response is loaded; an empty table
//   skips the scan, and a scan stops early at the first overlap
// one request at a time: the input stalls until the response is loaded, and a
//   stalled response side holds the block in its done state
// reset: synchronous, active low; clears the count and control, RAM untouched
`default_nettype none

module interval_booking_linear_scan (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ibls_pkg::t_req  i_in_req,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ibls_pkg::t_rsp       o_out_rsp
);

    ibls_pkg::t_state                  r_state, n_state;
    logic [ibls_pkg::COUNT_BITS-1:0]   r_idx, n_idx;
    logic [ibls_pkg::COUNT_BITS-1:0]   r_count, n_count;
    logic                              r_hit, n_hit;
    logic                              r_rd_vld, n_rd_vld;
    logic [ibls_pkg::TIME_BITS-1:0]    r_start, n_start;
    logic [ibls_pkg::TIME_BITS-1:0]    r_end, n_end;
    logic                              r_out_valid, n_out_valid;
    ibls_pkg::t_rsp                    r_out, n_out;

    logic                              ram_we;
    logic                              ram_re;
    logic [ibls_pkg::ENTRY_BITS-1:0]   ram_rdata;
    logic [ibls_pkg::TIME_BITS-1:0]    rd_start;
    logic [ibls_pkg::TIME_BITS-1:0]    rd_end;
    logic                              hit_now;
    logic                              load;
    logic                              full;

    // interval storage, start in the upper half and end in the lower half
    ibls_ram #(
        .WIDTH (ibls_pkg::ENTRY_BITS),
        .DEPTH (ibls_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ibls_pkg::ADDR_BITS-1:0]),
        .i_wdata ({r_start, r_end}),
        .i_re    (ram_re),
        .i_raddr (r_idx[ibls_pkg::ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ibls_pkg::ENTRY_BITS-1:ibls_pkg::TIME_BITS];
    assign rd_end   = ram_rdata[ibls_pkg::TIME_BITS-1:0];

    // overlap test on the entry read last cycle
    assign hit_now = r_rd_vld && (rd_start < r_end) && (rd_end > r_start);
    assign full    = (r_count == ibls_pkg::COUNT_BITS'(ibls_pkg::CAPACITY));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibls_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_hit   <= n_hit;
        r_start <= n_start;
        r_end   <= n_end;
        r_out   <= n_out;
    end

    // next state, scan sequencing and response build
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_count  = r_count;
        n_hit    = r_hit;
        n_start  = r_start;
        n_end    = r_end;
        n_out    = r_out;
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        load     = 1'b0;
        case (r_state)
            ibls_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_start = ibls_pkg::TIME_BITS'(i_in_req.start_time);
                    n_end   = ibls_pkg::TIME_BITS'(i_in_req.end_time);
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (r_count == '0) ? ibls_pkg::ST_DONE : ibls_pkg::ST_SCAN;
                end
            end
            ibls_pkg::ST_SCAN: begin
                n_hit = r_hit | hit_now;
                if ((r_idx < r_count) && !hit_now) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
                if (hit_now || ((r_idx == r_count) && !r_rd_vld)) begin
                    n_state = ibls_pkg::ST_DONE;
                end
            end
            ibls_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load = 1'b1;
                    if (r_hit) begin
                        n_out.status = ibls_pkg::STATUS_OVERLAP;
                    end else if (full) begin
                        n_out.status = ibls_pkg::STATUS_FULL;
                    end else begin
                        n_out.status = ibls_pkg::STATUS_OK;
                        ram_we       = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                    n_out.entries_used = ibls_pkg::FIELD_COUNT_BITS'(n_count);
                    n_state = ibls_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ibls_pkg::ST_IDLE;
            end
        endcase
        n_rd_vld    = ram_re;
        n_out_valid = load ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
    end

    assign o_in_stall  = (r_state != ibls_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // the count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ibls_pkg::COUNT_BITS'(ibls_pkg::CAPACITY))
        else $error("stored count beyond capacity");

    // an append only happens with room left and no overlap found
    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (!full && !r_hit && r_state == ibls_pkg::ST_DONE))
        else $error("append without room or after an overlap");

    // an append bumps the count by exactly one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + 1'b1))
        else $error("count not advanced on append");

    // the scan never issues a read past the stored entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_idx < r_count))
        else $error("read beyond stored entries");

    // a pending response is never overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !load)
        else $error("response loaded over a stalled one");

endmodule

`default_nettype wire

>>> hdl/ibls_ram.sv
// ---------------------------------------------------------------------------
// ibls_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ibls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
